/* hdl/wsdfr_pkg.sv */
// shared types and constants for the websocket frame deframer
package wsdfr_pkg;

  localparam int unsigned InDataW    = 8;
  localparam int unsigned OutDataW   = 88;
  localparam int unsigned OutUserW   = 3;
  localparam int unsigned QueueDepth = 2;

  localparam logic [6:0] Len7Ext16 = 7'd126;
  localparam logic [6:0] Len7Ext64 = 7'd127;
  localparam logic [3:0] ExtCnt16  = 4'd2;
  localparam logic [3:0] ExtCnt64  = 4'd8;
  localparam logic [3:0] KeyCnt    = 4'd4;

  // user bit positions on the result side
  localparam int unsigned UserHasByte = 0;
  localparam int unsigned UserCtrl    = 1;
  localparam int unsigned UserLastMsg = 2;

  typedef enum logic [4:0] {
    PH_HDR0 = 5'b00001,
    PH_HDR1 = 5'b00010,
    PH_EXT  = 5'b00100,
    PH_KEY  = 5'b01000,
    PH_DATA = 5'b10000
  } wsdfr_phase_e;

  // one classified word handed from the parser to the output stage
  typedef struct packed {
    logic [7:0]  data;
    logic [7:0]  key;
    logic        has;
    logic [3:0]  fop;
    logic [3:0]  mop;
    logic [2:0]  mrsv;
    logic        fin;
    logic        masked;
    logic [63:0] len;
    logic        last;
  } wsdfr_ent_t;

endpackage

/* hdl/wsdfr_front.sv */
// header parser: walks the frame header and classifies every payload byte
module wsdfr_front import wsdfr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       byte_i,
  output logic             push_o,
  output wsdfr_ent_t       ent_o
);

  wsdfr_phase_e phase_q, phase_d;
  logic        fin_q, fin_d;
  logic [2:0]  rsv_q, rsv_d;
  logic [3:0]  op_q, op_d;
  logic        mask_q, mask_d;
  logic [63:0] len_q, len_d;
  logic [63:0] left_q, left_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  kpos_q, kpos_d;
  logic [3:0]  mop_q, mop_d;
  logic [2:0]  mrsv_q, mrsv_d;
  logic        inmsg_q, inmsg_d;

  logic        ctrl;
  logic        do_after;
  logic        do_hdr;
  logic [6:0]  len7;
  logic [7:0]  kb;

  assign ctrl = op_q[3];
  assign len7 = byte_i[6:0];

  always_comb begin
    unique case (kpos_q)
      2'd0: kb = key_q[31:24];
      2'd1: kb = key_q[23:16];
      2'd2: kb = key_q[15:8];
      default: kb = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    fin_d    = fin_q;
    rsv_d    = rsv_q;
    op_d     = op_q;
    mask_d   = mask_q;
    len_d    = len_q;
    left_d   = left_q;
    cnt_d    = cnt_q;
    key_d    = key_q;
    kpos_d   = kpos_q;
    mop_d    = mop_q;
    mrsv_d   = mrsv_q;
    inmsg_d  = inmsg_q;
    do_after = 1'b0;
    do_hdr   = 1'b0;
    push_o   = 1'b0;
    ent_o    = '0;

    if (fire_i) begin
      unique case (phase_q)
        PH_HDR0: begin
          fin_d   = byte_i[7];
          rsv_d   = byte_i[6:4];
          op_d    = byte_i[3:0];
          phase_d = PH_HDR1;
        end
        PH_HDR1: begin
          mask_d = byte_i[7];
          if (len7 == Len7Ext16 || len7 == Len7Ext64) begin
            len_d   = '0;
            cnt_d   = (len7 == Len7Ext16) ? ExtCnt16 : ExtCnt64;
            phase_d = PH_EXT;
          end else begin
            len_d    = {57'd0, len7};
            do_after = 1'b1;
          end
        end
        PH_EXT: begin
          len_d = {len_q[55:0], byte_i};
          cnt_d = cnt_q - 4'd1;
          if (cnt_q == 4'd1) begin
            do_after = 1'b1;
          end
        end
        PH_KEY: begin
          key_d = {key_q[23:0], byte_i};
          cnt_d = cnt_q - 4'd1;
          if (cnt_q == 4'd1) begin
            do_hdr = 1'b1;
          end
        end
        PH_DATA: begin
          kpos_d = kpos_q + 2'd1;
          left_d = left_q - 64'd1;
          push_o = 1'b1;
          ent_o  = '{data: byte_i, key: kb, has: 1'b1, fop: op_q, mop: mop_q,
                     mrsv: mrsv_q, fin: fin_q, masked: mask_q, len: len_q,
                     last: (left_q == 64'd1)};
          if (left_q == 64'd1) begin
            if (!ctrl && fin_q) begin
              inmsg_d = 1'b0;
            end
            phase_d = PH_HDR0;
          end
        end
        default: begin
          phase_d = PH_HDR0;
        end
      endcase

      if (do_after) begin
        key_d = '0;
        if (mask_d) begin
          cnt_d   = KeyCnt;
          phase_d = PH_KEY;
        end else begin
          do_hdr = 1'b1;
        end
      end

      if (do_hdr) begin
        left_d = len_d;
        kpos_d = '0;
        if (!ctrl && !inmsg_q) begin
          mop_d   = op_q;
          mrsv_d  = rsv_q;
          inmsg_d = 1'b1;
        end
        if (len_d == 64'd0) begin
          // empty frame: one marker word with no byte
          push_o = 1'b1;
          ent_o  = '{data: 8'd0, key: 8'd0, has: 1'b0, fop: op_q, mop: mop_d,
                     mrsv: mrsv_d, fin: fin_q, masked: mask_d, len: len_d,
                     last: 1'b1};
          if (!ctrl && fin_q) begin
            inmsg_d = 1'b0;
          end
          phase_d = PH_HDR0;
        end else begin
          phase_d = PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      fin_q   <= 1'b0;
      rsv_q   <= '0;
      op_q    <= '0;
      mask_q  <= 1'b0;
      len_q   <= '0;
      left_q  <= '0;
      cnt_q   <= '0;
      key_q   <= '0;
      kpos_q  <= '0;
      mop_q   <= '0;
      mrsv_q  <= '0;
      inmsg_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      fin_q   <= fin_d;
      rsv_q   <= rsv_d;
      op_q    <= op_d;
      mask_q  <= mask_d;
      len_q   <= len_d;
      left_q  <= left_d;
      cnt_q   <= cnt_d;
      key_q   <= key_d;
      kpos_q  <= kpos_d;
      mop_q   <= mop_d;
      mrsv_q  <= mrsv_d;
      inmsg_q <= inmsg_d;
    end
  end

endmodule

/* hdl/wsdfr_queue.sv */
// short queue of classified words between parser and output stage
module wsdfr_queue import wsdfr_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  wsdfr_ent_t ent_i,
  output logic       full_o,
  input  logic       pop_i,
  output wsdfr_ent_t ent_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  wsdfr_ent_t            mem_q [Depth];
  logic [PtrW-1:0]       wr_q, wr_d;
  logic [PtrW-1:0]       rd_q, rd_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign ent_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= ent_i;
    end
  end

endmodule

/* hdl/wsdfr_back.sv */
// output stage: unmasks the byte, forms the result word and holds it for the sink
module wsdfr_back import wsdfr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  wsdfr_ent_t          ent_i,
  output logic                pop_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tlast_o,
  output logic [OutUserW-1:0] m_axis_tuser_o
);

  logic                vld_q;
  logic [OutDataW-1:0] data_q, data_d;
  logic                last_q;
  logic [OutUserW-1:0] user_q, user_d;
  logic                ctrl;
  logic [7:0]          pbyte;

  assign pop_o = !empty_i && (!vld_q || m_axis_tready_i);
  assign ctrl  = ent_i.fop[3];
  assign pbyte = ent_i.has ? (ent_i.data ^ ent_i.key) : 8'd0;

  always_comb begin
    data_d = {3'd0, ent_i.len, ent_i.masked, ent_i.fin,
              ctrl ? 3'd0 : ent_i.mrsv, ctrl ? 4'd0 : ent_i.mop, ent_i.fop, pbyte};
    user_d = '0;
    user_d[UserHasByte] = ent_i.has;
    user_d[UserCtrl]    = ctrl;
    user_d[UserLastMsg] = ent_i.last && !ctrl && ent_i.fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (pop_o) begin
      vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= data_d;
      last_q <= ent_i.last;
      user_q <= user_d;
    end
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tuser_o  = user_q;

endmodule

/* hdl/websocket_frame_deframer_unit.sv */
// top level of the websocket frame deframer: parser, queue and output stage
//
//   channel   dir  handshake                 payload
//   s_axis    in   s_axis_tvalid/tready      tdata[7:0] byte_in
//   m_axis    out  m_axis_tvalid/tready      tdata (88 bits), tlast, tuser (3 bits)
//
// one byte is taken every cycle while the queue has room; the parser state
// is updated in the cycle a byte is taken. a result is written into the queue
// at the edge that accepts its byte and then registered in the output stage
// before it is valid on m_axis; a stall on m_axis holds it in the queue.
// reset clears the parser, queue pointers and output valid.
// when m_axis stalls the queue absorbs words, and s_axis_tready_o drops
// whenever the queue is full, even in a cycle in which a word is popped.
module websocket_frame_deframer_unit import wsdfr_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // [7:0] byte_in
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [7:0] payload_byte, [11:8] frame_opcode, [15:12] message_opcode,
  // [18:16] message_rsv, [19] fin_flag, [20] was_masked, [84:21] frame_length
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tlast_o,   // last_of_frame
  // [0] has_byte, [1] is_control, [2] last_of_message
  output logic [OutUserW-1:0] m_axis_tuser_o
);

  logic       fire;
  logic       push;
  logic       full;
  logic       pop;
  logic       empty;
  wsdfr_ent_t ent_in;
  wsdfr_ent_t ent_out;

  assign s_axis_tready_o = !full;
  assign fire            = s_axis_tvalid_i && s_axis_tready_o;

  wsdfr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (s_axis_tdata_i),
    .push_o (push),
    .ent_o  (ent_in)
  );

  wsdfr_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ent_i   (ent_in),
    .full_o  (full),
    .pop_i   (pop),
    .ent_o   (ent_out),
    .empty_o (empty)
  );

  wsdfr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .ent_i           (ent_out),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

`ifndef SYNTH
  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full && !pop |-> !push)
    else $error("word pushed into a full queue");

  a_empty_marker_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[UserHasByte] |->
      m_axis_tlast_o && m_axis_tdata_o[7:0] == 8'd0)
    else $error("empty frame marker is not the last word of its frame");

  a_msg_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[UserLastMsg] |->
      m_axis_tlast_o && !m_axis_tuser_o[UserCtrl] && m_axis_tdata_o[19])
    else $error("message end outside the last word of a final data frame");
`endif

endmodule
